>>> hdl/modem_adapter_registers_defines.svh
// assertion macros used by the checker file
`ifndef MODEM_ADAPTER_REGISTERS_DEFINES_SVH
`define MODEM_ADAPTER_REGISTERS_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modem adapter check failed");

// next-cycle implication, disabled while reset is low
`define MAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modem adapter check failed");

`endif

>>> hdl/mar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mar_pkg;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_POLL  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // register offsets (read meaning / write meaning)
    localparam logic [1:0] OFS_STAT_FMT   = 2'd0;
    localparam logic [1:0] OFS_DATA       = 2'd1;
    localparam logic [1:0] OFS_MODEM_RATE = 2'd2;
    localparam logic [1:0] OFS_MASK_CTRL  = 2'd3;

    // uart status bits
    localparam int ST_TBMT = 0;
    localparam int ST_DAV  = 1;
    localparam int ST_TEOC = 2;
    localparam int ST_PE   = 3;
    localparam int ST_OE   = 4;
    localparam int ST_FE   = 5;

    // modem status bits, active low except the timer pulse
    localparam int MS_DT  = 0;
    localparam int MS_RNG = 1;
    localparam int MS_CTS = 2;
    localparam int MS_AP  = 4;
    localparam int MS_TMR = 7;

    // format and control bits
    localparam int FMT_SH  = 0;
    localparam int FMT_RI  = 1;
    localparam int CTL_DTR = 6;

    // divider sizing
    localparam int DIV_W     = 14;
    localparam int DVS_W     = 12;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // arithmetic constants
    localparam int BAUD_CLOCK = 250000;
    localparam logic [DIV_W-1:0] BAUD_NUM       = DIV_W'(BAUD_CLOCK / 16);
    localparam logic [DIV_W-1:0] PULSE_BASE     = DIV_W'(2500);
    localparam logic [DIV_W-1:0] PULSE_LOW_MS   = DIV_W'(600);
    localparam logic [DIV_W-1:0] PULSE_HIGH_MS  = DIV_W'(400);
    localparam logic [6:0]       PULSE_NO_RATE  = 7'd100;
    localparam logic [6:0]       PULSE_RESET    = 7'd40;
    localparam logic [8:0]       DIALTONE_MS    = 9'd500;
    localparam logic [13:0]      BAUD_RESET     = 14'd300;
    localparam logic [7:0]       MODEM_RESET    = 8'h17;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
        logic       new_connection;
        logic       cts_in;
        logic       ring_in;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_line_done;
        logic       tx_lost;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        dtr_level;
        logic        rts_level;
        logic        receiver_enable;
        logic [3:0]  word_bits;
        logic [1:0]  parity_mode;
        logic        two_stop_bits;
        logic [13:0] baud_rate;
    } t_out_item;

    // divider operand selection
    typedef enum logic [1:0] {
        DOP_BAUD = 2'd0,
        DOP_PER1 = 2'd1,
        DOP_PER2 = 2'd2
    } t_div_op;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    exec;
        logic    div_start;
        t_div_op div_op;
        logic    load_baud;
        logic    load_pulse;
        logic    load_out;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_baud;
        logic need_tick;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/mar_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface mar_in_if;
    import mar_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface mar_out_if;
    import mar_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/modem_adapter_registers.sv
// channel   direction  payload
// i_in      sink       command, register offset, write byte, line poll fields
// o_out     source     read byte, sent byte, line levels, line format, baud rate
// cfg       write only rts_follows_dtr on i_cfg_wr_en / i_cfg_wr_data
//
// a read, a write, a line poll or a plain tick executes after the input
// transfer and loads its result once the output register is free; a nonzero
// rate write adds one pass of the shared 14-step divider, and a tick reloading
// the pulse countdown adds two chained passes. one item is in work at a time.
// reset is synchronous; it restores the state registers and clears output valid.
// a stalled result holds in the output register while the next item is taken in.
`timescale 1ns / 1ps
`default_nettype none

module modem_adapter_registers (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire logic  i_cfg_wr_data,
    mar_in_if.sink     i_in,
    mar_out_if.source  o_out
);
    import mar_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    // sequencer
    mar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    // registers, divider and result register
    mar_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_in.data),
        .i_out_ready   (o_out.ready),
        .i_cmd         (ctrl_cmd),
        .o_sts         (dp_sts),
        .o_out_valid   (out_valid),
        .o_out_data    (out_data)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;

endmodule

`default_nettype wire

>>> hdl/mar_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mar_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [mar_pkg::DVS_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [mar_pkg::DIV_W-1:0]        o_quot
);
    import mar_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_quot;
    logic [DVS_W:0]       trial;
    logic                 fits;

    // one restoring step: shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quot[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
            r_quot <= {r_quot[DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> hdl/mar_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire mar_pkg::t_in_item  i_item,
    input  wire logic               i_out_ready,
    input  wire mar_pkg::t_ctrl_cmd i_cmd,
    output mar_pkg::t_dp_sts        o_sts,
    output logic                    o_out_valid,
    output mar_pkg::t_out_item      o_out_data
);
    import mar_pkg::*;

    // configuration and captured item
    logic      r_rts_follows;
    t_in_item  r_item;

    // block state
    logic [5:0]  r_uart,   n_uart;
    logic [7:0]  r_rx,     n_rx;
    logic [7:0]  r_modem,  n_modem;
    logic [7:0]  r_fmt,    n_fmt;
    logic [7:0]  r_tx,     n_tx;
    logic [7:0]  r_rate,   n_rate;
    logic [7:0]  r_ctrl,   n_ctrl;
    logic [7:0]  r_mask,   n_mask;
    logic        r_txpend, n_txpend;
    logic        r_conn,   n_conn;
    logic [13:0] r_baud;
    logic [6:0]  r_pulse,  n_pulse;
    logic [8:0]  r_dial,   n_dial;
    logic [1:0]  r_lvl,    n_lvl;

    // per-item results
    logic [7:0]  r_rd,  n_rd;
    logic        r_txv, n_txv;
    logic [7:0]  r_txb, n_txb;

    // output register
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   out_next;
    logic [1:0]  line_mask;
    logic [1:0]  par;

    // divider hookup
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;

    assign line_mask = {r_rts_follows, 1'b1};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rts_follows <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_rts_follows <= i_cfg_wr_data;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // command execution, everything but the divisions
    always_comb begin
        n_uart   = r_uart;
        n_rx     = r_rx;
        n_modem  = r_modem;
        n_fmt    = r_fmt;
        n_tx     = r_tx;
        n_rate   = r_rate;
        n_ctrl   = r_ctrl;
        n_mask   = r_mask;
        n_txpend = r_txpend;
        n_conn   = r_conn;
        n_pulse  = r_pulse;
        n_dial   = r_dial;
        n_lvl    = r_lvl;
        n_rd     = '0;
        n_txv    = 1'b0;
        n_txb    = '0;
        case (r_item.cmd)
            CMD_READ: begin
                case (r_item.reg_addr)
                    OFS_STAT_FMT: begin
                        n_rd = {2'b00, r_uart};
                    end
                    OFS_DATA: begin
                        n_rd          = r_rx;
                        n_uart[ST_DAV] = 1'b0;
                        n_uart[ST_PE] = 1'b0;
                        n_uart[ST_OE] = 1'b0;
                        n_uart[ST_FE] = 1'b0;
                    end
                    OFS_MODEM_RATE: begin
                        n_rd = r_modem;
                    end
                    default: begin
                        n_mask = r_rate;
                    end
                endcase
            end
            CMD_WRITE: begin
                case (r_item.reg_addr)
                    OFS_STAT_FMT: begin
                        n_fmt = r_item.write_data;
                        if (r_item.write_data[FMT_SH]) begin
                            n_dial         = DIALTONE_MS;
                            n_modem[MS_AP] = 1'b0;
                        end else if (!r_modem[MS_DT]) begin
                            n_dial         = '0;
                            n_modem[MS_DT] = 1'b1;
                        end
                        if (r_item.write_data[FMT_RI]) begin
                            n_modem[MS_AP] = 1'b0;
                        end
                    end
                    OFS_DATA: begin
                        n_tx            = r_item.write_data;
                        n_uart[ST_TBMT] = 1'b0;
                        n_uart[ST_TEOC] = 1'b0;
                        n_txpend        = 1'b1;
                    end
                    OFS_MODEM_RATE: begin
                        n_rate = r_item.write_data;
                    end
                    default: begin
                        n_ctrl = r_item.write_data;
                        if (r_item.write_data[CTL_DTR]) begin
                            n_lvl = r_lvl | line_mask;
                            if (r_fmt[FMT_SH]) begin
                                n_modem[MS_AP] = 1'b0;
                            end
                        end else begin
                            n_lvl          = r_lvl & ~line_mask;
                            n_modem[MS_AP] = 1'b1;
                        end
                    end
                endcase
            end
            CMD_POLL: begin
                if (r_item.new_connection) begin
                    n_lvl  = r_lvl & ~line_mask;
                    n_conn = 1'b1;
                end
                // cts going inactive sets answer phone
                n_modem[MS_CTS] = ~r_item.cts_in;
                if ((r_modem[MS_CTS] != n_modem[MS_CTS]) && n_modem[MS_CTS]) begin
                    n_modem[MS_AP] = 1'b1;
                end
                // ring going active clears answer phone
                n_modem[MS_RNG] = ~r_item.ring_in;
                if ((r_modem[MS_RNG] != n_modem[MS_RNG]) && !n_modem[MS_RNG]) begin
                    n_modem[MS_AP] = 1'b0;
                end
                // send the pending byte while cts is active
                if (r_txpend && !n_modem[MS_CTS]) begin
                    n_txv    = 1'b1;
                    n_txb    = r_tx;
                    n_txpend = 1'b0;
                    if (r_item.tx_lost) begin
                        n_conn = 1'b0;
                    end
                end
                if (!n_txpend && !r_uart[ST_TBMT] && r_item.tx_line_done && n_conn) begin
                    n_uart[ST_TBMT] = 1'b1;
                    n_uart[ST_TEOC] = 1'b1;
                end
                // receive latch
                if (!n_uart[ST_DAV] && r_item.rx_valid) begin
                    n_rx           = r_item.rx_byte;
                    n_uart[ST_DAV] = 1'b1;
                    n_uart[ST_PE]  = 1'b0;
                    n_uart[ST_OE]  = 1'b0;
                    n_uart[ST_FE]  = 1'b0;
                end
            end
            default: begin
                // millisecond tick: pulse countdown, divider reload when the rate is nonzero
                if (r_pulse == '0) begin
                    if (r_rate != '0) begin
                        n_modem[MS_TMR] = ~r_modem[MS_TMR];
                    end else begin
                        n_pulse = PULSE_NO_RATE;
                    end
                end else begin
                    n_pulse = r_pulse - 1'b1;
                end
                // dial tone countdown
                if (r_dial == '0) begin
                    if (r_fmt[FMT_SH] && r_modem[MS_DT]) begin
                        n_modem[MS_DT] = 1'b0;
                    end
                end else begin
                    n_dial = r_dial - 1'b1;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uart   <= '0;
            r_rx     <= '0;
            r_modem  <= MODEM_RESET;
            r_fmt    <= '0;
            r_tx     <= '0;
            r_rate   <= '0;
            r_ctrl   <= '0;
            r_mask   <= '0;
            r_txpend <= 1'b0;
            r_conn   <= 1'b0;
            r_baud   <= BAUD_RESET;
            r_pulse  <= PULSE_RESET;
            r_dial   <= '0;
            r_lvl    <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_uart   <= n_uart;
                r_rx     <= n_rx;
                r_modem  <= n_modem;
                r_fmt    <= n_fmt;
                r_tx     <= n_tx;
                r_rate   <= n_rate;
                r_ctrl   <= n_ctrl;
                r_mask   <= n_mask;
                r_txpend <= n_txpend;
                r_conn   <= n_conn;
                r_pulse  <= n_pulse;
                r_dial   <= n_dial;
                r_lvl    <= n_lvl;
            end
            if (i_cmd.load_baud) begin
                r_baud <= div_quot[13:0];
            end
            if (i_cmd.load_pulse) begin
                r_pulse <= div_quot[6:0];
            end
        end
    end

    // per-item results
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd  <= n_rd;
            r_txv <= n_txv;
            r_txb <= n_txb;
        end
    end

    // divider operands
    always_comb begin
        case (i_cmd.div_op)
            DOP_BAUD: begin
                // the rate register loads at the same edge, so use its next value
                div_dividend = BAUD_NUM;
                div_divisor  = DVS_W'(n_rate);
            end
            DOP_PER1: begin
                div_dividend = PULSE_BASE;
                div_divisor  = DVS_W'(r_rate);
            end
            DOP_PER2: begin
                // pulse bit already toggled: low phase is the longer one
                div_dividend = r_modem[MS_TMR] ? PULSE_HIGH_MS : PULSE_LOW_MS;
                div_divisor  = div_quot[DVS_W-1:0];
            end
            default: begin
                div_dividend = BAUD_NUM;
                div_divisor  = DVS_W'(n_rate);
            end
        endcase
    end

    mar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // result assembly from the updated state
    assign par = r_fmt[5:4];
    always_comb begin
        out_next.read_data       = r_rd;
        out_next.tx_valid        = r_txv;
        out_next.tx_byte         = r_txb;
        out_next.dtr_level       = r_lvl[0];
        out_next.rts_level       = r_lvl[1];
        out_next.receiver_enable = ~r_modem[MS_CTS];
        out_next.word_bits       = 4'd5 + {2'b00, r_fmt[3:2]};
        case (par)
            2'd0:    out_next.parity_mode = 2'd0;
            2'd2:    out_next.parity_mode = 2'd2;
            default: out_next.parity_mode = 2'd1;
        endcase
        out_next.two_stop_bits   = r_fmt[6];
        out_next.baud_rate       = r_baud;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= out_next;
        end
    end

    // status back to the controller
    assign o_sts.need_baud = (r_item.cmd == CMD_WRITE) && (r_item.reg_addr == OFS_MODEM_RATE)
                             && (r_item.write_data != '0);
    assign o_sts.need_tick = (r_item.cmd == CMD_TICK) && (r_pulse == '0) && (r_rate != '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/mar_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire mar_pkg::t_dp_sts i_sts,
    output mar_pkg::t_ctrl_cmd    o_cmd
);
    import mar_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_DIVB  = 6'b000100,
        S_DIVP1 = 6'b001000,
        S_DIVP2 = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.div_op     = DOP_BAUD;
        o_cmd.load_baud  = 1'b0;
        o_cmd.load_pulse = 1'b0;
        o_cmd.load_out   = 1'b0;
        o_in_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_baud) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_BAUD;
                    n_state         = S_DIVB;
                end else if (i_sts.need_tick) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_PER1;
                    n_state         = S_DIVP1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIVB: begin
                if (i_sts.div_done) begin
                    o_cmd.load_baud = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_DIVP1: begin
                // chain the second division off the first quotient
                o_cmd.div_op = DOP_PER2;
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVP2;
                end
            end
            S_DIVP2: begin
                if (i_sts.div_done) begin
                    o_cmd.load_pulse = 1'b1;
                    n_state          = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mar_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "modem_adapter_registers_defines.svh"

module mar_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire mar_pkg::t_out_item i_out_data
);
    import mar_pkg::*;

    // a stalled result stays offered
    `MAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // one item in work at a time
    `MAR_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // no sent byte means a zero byte field
    `MAR_ASSERT_IMP(a_tx_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.tx_valid, i_out_data.tx_byte == 8'd0)

    // line format stays in its legal range
    `MAR_ASSERT_IMP(a_format, i_clk, i_rst_n, i_out_valid, (i_out_data.word_bits >= 4'd5) && (i_out_data.word_bits <= 4'd8) && (i_out_data.parity_mode != 2'd3))

    // the baud rate is never zero
    `MAR_ASSERT_IMP(a_baud, i_clk, i_rst_n, i_out_valid, i_out_data.baud_rate != 14'd0)

endmodule

bind modem_adapter_registers mar_checker u_mar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
